// ----- src/tmd_pkg.sv -----
`timescale 1ns / 1ps

package tmd_pkg;

   // Framing constants
   localparam logic [31:0] MAGIC_WORD  = 32'h444D_4140;   // "DMA@"
   localparam int          HEADER_LEN  = 8;
   localparam int          TRAILER_LEN = 4;

   // Result kinds
   typedef enum logic [1:0] {
      KIND_BYTE  = 2'd0,
      KIND_GOOD  = 2'd1,
      KIND_LOST  = 2'd2,
      KIND_OTHER = 2'd3
   } kind_type;

   // Parser phase, one-hot
   typedef enum logic [2:0] {
      PH_HEADER  = 3'b001,
      PH_PAYLOAD = 3'b010,
      PH_TRAILER = 3'b100
   } phase_type;

   // Configuration register indexes
   typedef enum logic {
      REG_ACCEPTED_TYPE = 1'b0,
      REG_MAX_KEEP      = 1'b1
   } reg_index_type;

   // One result word as handed from the parser to the output register
   typedef struct packed {
      kind_type   kind;
      logic [7:0] payload_byte;
   } result_type;

   // Expected trailer byte at each position: "CMPH"
   function automatic logic [7:0] trailer_char(input logic [1:0] idx);
      logic [7:0] ch;
      case (idx)
         2'd0:    ch = 8'h43;
         2'd1:    ch = 8'h4D;
         2'd2:    ch = 8'h50;
         default: ch = 8'h48;
      endcase
      return ch;
   endfunction

endpackage

// ----- src/tagged_message_deframer_unit.sv -----
`timescale 1ns / 1ps

// Tagged message deframer: takes one link byte per word and parses frames of
// "DMA@", a type byte, a 24-bit big-endian size, the payload padded to even
// length and the trailer "CMPH". Kept payload bytes come out with tuser 0; each
// message closes with one word whose tuser says good (1), lost (2) or another
// type (3). One byte is taken every clock cycle when the output side keeps up;
// a byte's result reaches the output through the input register, the parser
// logic and the result register; the rate is set by the parser state update.
// Configuration (index 0 accepted type, index 1 max kept size) is to be written
// by the user between messages; the block itself does not enforce this. Values
// are sampled when a header completes.
module tagged_message_deframer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // [7:0] link_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [7:0]  rsp_tdata,    // [7:0] payload_byte
   output logic [1:0]  rsp_tuser,    // [1:0] kind
   input  logic        csr_we,
   input  logic        csr_index,
   input  logic [23:0] csr_wdata
);
   import tmd_pkg::*;

   logic       in_valid;
   logic [7:0] in_byte;
   logic       out_free;
   logic       advance;
   logic       res_valid;
   result_type res;

   // Held word moves into the parser when the result register has room
   assign advance = in_valid && out_free;

   tmd_in_stage u_in (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .advance    (advance),
      .in_valid   (in_valid),
      .in_byte    (in_byte)
   );

   tmd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .link_byte (in_byte),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .res_valid (res_valid),
      .res       (res)
   );

   tmd_out_stage u_out (
      .clock      (clock),
      .reset      (reset),
      .advance    (advance),
      .res_valid  (res_valid),
      .res        (res),
      .out_free   (out_free),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

endmodule

// ----- src/tmd_in_stage.sv -----
`timescale 1ns / 1ps

module tmd_in_stage (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,    // [7:0] link_byte
   input  logic       advance,
   output logic       in_valid,
   output logic [7:0] in_byte
);

   logic       in_valid_ff;
   logic       in_valid_in;
   logic [7:0] in_byte_ff;

   // Slot is free when empty or when the held word moves on this cycle
   assign req_tready = !in_valid_ff || advance;

   always_comb begin
      if (req_tvalid && req_tready) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end else begin
         in_valid_in = in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   // Data word, no reset needed
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   assign in_valid = in_valid_ff;
   assign in_byte  = in_byte_ff;

endmodule

// ----- src/tmd_parser.sv -----
`timescale 1ns / 1ps

module tmd_parser (
   input  logic                clock,
   input  logic                reset,
   input  logic                step,
   input  logic [7:0]          link_byte,
   input  logic                csr_we,
   input  logic                csr_index,
   input  logic [23:0]         csr_wdata,
   output logic                res_valid,
   output tmd_pkg::result_type res
);
   import tmd_pkg::*;

   // Configuration
   logic [7:0]  accepted_type_ff;
   logic [23:0] max_keep_ff;

   // Frame state
   phase_type   phase_ff, phase_in;
   logic [23:0] byte_count_ff, byte_count_in;
   logic [55:0] header_ff, header_in;
   logic [23:0] payload_size_ff, payload_size_in;
   logic [23:0] last_idx_ff, last_idx_in;
   logic        passing_ff, passing_in;
   logic        type_match_ff, type_match_in;
   logic        trailer_bad_ff, trailer_bad_in;

   logic [63:0] hdr_word;
   logic [23:0] new_size;
   logic        bad_now;

   assign hdr_word = {header_ff, link_byte};
   assign new_size = hdr_word[23:0];
   assign bad_now  = trailer_bad_ff || (link_byte != trailer_char(byte_count_ff[1:0]));

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         accepted_type_ff <= 8'd1;
         max_keep_ff      <= 24'd1024;
      end else if (csr_we) begin
         case (csr_index)
            REG_ACCEPTED_TYPE: accepted_type_ff <= csr_wdata[7:0];
            REG_MAX_KEEP:      max_keep_ff      <= csr_wdata;
            default:           ;
         endcase
      end
   end

   // Next state and result for the word in the input register
   always_comb begin
      phase_in        = phase_ff;
      byte_count_in   = byte_count_ff;
      header_in       = header_ff;
      payload_size_in = payload_size_ff;
      last_idx_in     = last_idx_ff;
      passing_in      = passing_ff;
      type_match_in   = type_match_ff;
      trailer_bad_in  = trailer_bad_ff;
      res_valid       = 1'b0;
      res.kind        = KIND_BYTE;
      res.payload_byte = 8'd0;

      case (phase_ff)
         PH_PAYLOAD: begin
            // pad byte and dropped payloads give nothing
            if (passing_ff && (byte_count_ff < payload_size_ff)) begin
               res_valid        = 1'b1;
               res.payload_byte = link_byte;
            end
            if (byte_count_ff >= last_idx_ff) begin
               phase_in      = PH_TRAILER;
               byte_count_in = 24'd0;
            end else begin
               byte_count_in = byte_count_ff + 24'd1;
            end
         end

         PH_TRAILER: begin
            if (byte_count_ff[1:0] != 2'(TRAILER_LEN - 1)) begin
               byte_count_in  = {22'd0, byte_count_ff[1:0]} + 24'd1;
               trailer_bad_in = bad_now;
            end else begin
               phase_in      = PH_HEADER;
               byte_count_in = 24'd0;
               header_in     = 56'd0;
               res_valid     = 1'b1;
               if (bad_now) begin
                  res.kind = KIND_LOST;
               end else if (type_match_ff) begin
                  res.kind = passing_ff ? KIND_GOOD : KIND_LOST;
               end else begin
                  res.kind = KIND_OTHER;
               end
            end
         end

         default: begin
            // header collection
            phase_in  = PH_HEADER;
            header_in = hdr_word[55:0];
            if (byte_count_ff[2:0] != 3'(HEADER_LEN - 1)) begin
               byte_count_in = {21'd0, byte_count_ff[2:0]} + 24'd1;
            end else if (hdr_word[63:32] != MAGIC_WORD) begin
               // wrong magic: report and start over
               byte_count_in = 24'd0;
               header_in     = 56'd0;
               res_valid     = 1'b1;
               res.kind      = KIND_LOST;
            end else begin
               payload_size_in = new_size;
               last_idx_in     = new_size - {23'd0, ~new_size[0]};
               type_match_in   = (hdr_word[31:24] == accepted_type_ff);
               passing_in      = (hdr_word[31:24] == accepted_type_ff)
                                 && (new_size <= max_keep_ff);
               trailer_bad_in  = 1'b0;
               byte_count_in   = 24'd0;
               phase_in        = (new_size == 24'd0) ? PH_TRAILER : PH_PAYLOAD;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff        <= PH_HEADER;
         byte_count_ff   <= 24'd0;
         header_ff       <= 56'd0;
         payload_size_ff <= 24'd0;
         passing_ff      <= 1'b0;
         type_match_ff   <= 1'b0;
         trailer_bad_ff  <= 1'b0;
      end else if (step) begin
         phase_ff        <= phase_in;
         byte_count_ff   <= byte_count_in;
         header_ff       <= header_in;
         payload_size_ff <= payload_size_in;
         passing_ff      <= passing_in;
         type_match_ff   <= type_match_in;
         trailer_bad_ff  <= trailer_bad_in;
      end
   end

   // Only meaningful in payload phase, set with the header
   always_ff @(posedge clock) begin
      if (step) begin
         last_idx_ff <= last_idx_in;
      end
   end

   // Checks
   a_payload_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_PAYLOAD |-> byte_count_ff <= last_idx_ff)
      else $error("payload count beyond padded length");

   a_trailer_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_TRAILER |-> byte_count_ff < 24'(TRAILER_LEN))
      else $error("trailer count out of range");

   a_header_count: assert property (@(posedge clock) disable iff (reset)
      phase_ff == PH_HEADER |-> byte_count_ff < 24'(HEADER_LEN))
      else $error("header count out of range");

   a_byte_only_kept: assert property (@(posedge clock) disable iff (reset)
      step && res_valid && res.kind == KIND_BYTE |-> passing_ff && phase_ff == PH_PAYLOAD)
      else $error("payload byte from a dropped message");

endmodule

// ----- src/tmd_out_stage.sv -----
`timescale 1ns / 1ps

module tmd_out_stage (
   input  logic                clock,
   input  logic                reset,
   input  logic                advance,
   input  logic                res_valid,
   input  tmd_pkg::result_type res,
   output logic                out_free,
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   output logic [7:0]          rsp_tdata,   // [7:0] payload_byte
   output logic [1:0]          rsp_tuser    // [1:0] kind
);
   import tmd_pkg::*;

   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   result_type rsp_word_ff;

   // Register can take a new word when empty or being drained
   assign out_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      if (advance) begin
         rsp_valid_in = res_valid;
      end else begin
         rsp_valid_in = rsp_valid_ff && !rsp_tready;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && res_valid) begin
         rsp_word_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_word_ff.payload_byte;
   assign rsp_tuser  = rsp_word_ff.kind;

endmodule
